### rtl/core/bankers_safe_allocator_assert.svh
// Assertion macros shared by the checker of the safe allocator.
// Depends on nothing; included by the files that assert.
`ifndef BANKERS_SAFE_ALLOCATOR_ASSERT_SVH
`define BANKERS_SAFE_ALLOCATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BSA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bankers safe allocator: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define BSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bankers safe allocator: assertion failed");

`endif

### rtl/core/bsa_pkg.sv
// Package of the safe allocator: field widths, codes, controller states and
// the command and status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bsa_pkg;

  localparam int NUM_LANES  = 4;
  localparam int LANE_W     = 8;
  localparam int PIDX_W     = 3;
  localparam int STATUS_W   = 3;
  localparam int PCNT_W     = 4;
  localparam int RCNT_W     = 3;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Register index as decoded from the word address.
  localparam logic REG_PROC_COUNT = 1'b0;
  localparam logic REG_RES_COUNT  = 1'b1;

  localparam logic [PCNT_W-1:0] PROC_COUNT_RST = 4'd8;
  localparam logic [RCNT_W-1:0] RES_COUNT_RST  = 3'd4;

  typedef enum logic [1:0] {
    REQ_LOAD_ROW     = 2'd0,
    REQ_SET_AVAIL    = 2'd1,
    REQ_REQUEST      = 2'd2,
    REQ_SAFETY_CHECK = 2'd3
  } req_type_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK            = 3'd0,
    STS_EXCEEDS_NEED  = 3'd1,
    STS_EXCEEDS_AVAIL = 3'd2,
    STS_UNSAFE        = 3'd3,
    STS_BAD_ROW       = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_DECODE,
    CS_REQ_CHECK,
    CS_SEARCH_INIT,
    CS_SEARCH,
    CS_UNDO,
    CS_EMIT
  } ctrl_state_t;

  typedef logic [LANE_W-1:0] lane_amount_t;
  typedef lane_amount_t [NUM_LANES-1:0] lane_vec_t;

  typedef struct packed {
    logic    capture;
    logic    load_row;
    logic    set_avail;
    logic    read_req_row;
    logic    apply_req;
    logic    undo_req;
    logic    search_init;
    logic    search_run;
    logic    emit_step;
    logic    single_vld;
    status_t single_status;
  } dp_cmd_t;

  typedef struct packed {
    req_type_t req_type;
    logic      row_bad;
    logic      limit_bad;
    status_t   refuse_status;
    logic      search_done;
    logic      search_fail;
    logic      emit_last;
  } dp_sts_t;

endpackage

`default_nettype wire

### rtl/core/bsa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module bsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### rtl/core/bsa_ctrl.sv
// Controller state machine of the safe allocator: sequences decode, request
// check, safety search, undo and order emission. Depends on bsa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bsa_ctrl import bsa_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  output logic    busy,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CS_IDLE: begin
        if (start) state_nxt = CS_DECODE;
      end
      CS_DECODE: begin
        case (sts.req_type)
          REQ_SAFETY_CHECK: state_nxt = CS_SEARCH_INIT;
          REQ_REQUEST:      state_nxt = sts.row_bad ? CS_IDLE : CS_REQ_CHECK;
          default:          state_nxt = CS_IDLE;
        endcase
      end
      CS_REQ_CHECK: begin
        state_nxt = (sts.refuse_status != STS_OK) ? CS_IDLE : CS_SEARCH_INIT;
      end
      CS_SEARCH_INIT: state_nxt = CS_SEARCH;
      CS_SEARCH: begin
        if (sts.search_done) begin
          state_nxt = CS_EMIT;
        end else if (sts.search_fail) begin
          state_nxt = (sts.req_type == REQ_REQUEST) ? CS_UNDO : CS_IDLE;
        end
      end
      CS_UNDO: state_nxt = CS_IDLE;
      CS_EMIT: begin
        if (sts.emit_last) state_nxt = CS_IDLE;
      end
      default: state_nxt = CS_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.single_status = STS_OK;
    busy = (state_r != CS_IDLE);
    case (state_r)
      CS_IDLE: begin
        cmd.capture = start;
      end
      CS_DECODE: begin
        case (sts.req_type)
          REQ_LOAD_ROW: begin
            cmd.single_vld = 1'b1;
            if (sts.row_bad || sts.limit_bad) begin
              cmd.single_status = STS_BAD_ROW;
            end else begin
              cmd.load_row = 1'b1;
            end
          end
          REQ_SET_AVAIL: begin
            cmd.set_avail  = 1'b1;
            cmd.single_vld = 1'b1;
          end
          REQ_REQUEST: begin
            if (sts.row_bad) begin
              cmd.single_vld    = 1'b1;
              cmd.single_status = STS_BAD_ROW;
            end else begin
              cmd.read_req_row = 1'b1;
            end
          end
          default: ;
        endcase
      end
      CS_REQ_CHECK: begin
        if (sts.refuse_status != STS_OK) begin
          cmd.single_vld    = 1'b1;
          cmd.single_status = sts.refuse_status;
        end else begin
          cmd.apply_req = 1'b1;
        end
      end
      CS_SEARCH_INIT: cmd.search_init = 1'b1;
      CS_SEARCH: begin
        cmd.search_run = 1'b1;
        // A failed safety check answers at once; a failed request is undone first.
        if (sts.search_fail && sts.req_type != REQ_REQUEST) begin
          cmd.single_vld    = 1'b1;
          cmd.single_status = STS_UNSAFE;
        end
      end
      CS_UNDO: begin
        cmd.undo_req      = 1'b1;
        cmd.single_vld    = 1'b1;
        cmd.single_status = STS_UNSAFE;
      end
      CS_EMIT: cmd.emit_step = 1'b1;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/bsa_datapath.sv
// Datapath of the safe allocator: row table, available and work vectors,
// search scan, safe-order store and result registers. Depends on bsa_pkg, bsa_ram.
`timescale 1ns / 1ps
`default_nettype none

module bsa_datapath import bsa_pkg::*; #(
  parameter int MAX_PROCS = 8,
  parameter int MAX_RES = 4,
  parameter int AMOUNT_WIDTH = 8,
  localparam int CNT_W = $clog2(MAX_PROCS + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dp_cmd_t             cmd,
  output dp_sts_t             sts,
  input  logic [CNT_W-1:0]    np,
  input  logic [RCNT_W-1:0]   nr,
  input  logic [1:0]          in_req_type,
  input  logic [PIDX_W-1:0]   in_process_index,
  input  lane_vec_t           in_amount,
  input  lane_vec_t           in_limit,
  output logic                out_strobe,
  output logic [STATUS_W-1:0] out_status,
  output logic [PIDX_W-1:0]   out_order_process,
  output logic                out_last
);

  localparam int IDX_W  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int WORK_W = AMOUNT_WIDTH + CNT_W;
  localparam int ROW_W  = 2 * MAX_RES * AMOUNT_WIDTH;
  localparam int CMP_W  = (CNT_W > PIDX_W) ? CNT_W : PIDX_W;

  typedef logic [AMOUNT_WIDTH-1:0] amt_t;
  typedef amt_t [MAX_RES-1:0]      amt_vec_t;
  typedef logic [WORK_W-1:0]       work_t;

  // Captured transaction.
  req_type_t         req_type_r;
  logic [PIDX_W-1:0] pidx_r;
  amt_vec_t          amt_r, lim_r;

  amt_vec_t          avail_r, avail_nxt;
  logic [ROW_W-1:0]  backup_r;
  logic [MAX_PROCS-1:0] row_valid_r;
  logic              rd_valid_r;

  work_t [MAX_RES-1:0] work_r, work_nxt;
  logic [MAX_PROCS-1:0] fin_r;
  logic [CNT_W-1:0]  taken_r, scan_r, emit_r;
  logic [IDX_W-1:0]  cmp_idx_r;
  logic              cmp_vld_r;

  logic              res_vld_r, res_last_r, res_from_ord_r;
  status_t           res_status_r;

  logic              row_we;
  logic [IDX_W-1:0]  row_waddr, row_raddr;
  logic [ROW_W-1:0]  row_wdata, row_rdata, row_cur;
  amt_vec_t          cur_alloc, cur_need;
  amt_vec_t          ld_alloc, ld_need, ap_alloc, ap_need;
  logic [MAX_RES-1:0] lane_on;
  logic              limit_bad, row_bad, fits, issue_vld, hit, pass_end;
  logic              search_done, search_fail, emit_last;
  status_t           refuse;
  logic [PIDX_W-1:0] ord_rdata;

  // A row never written reads as all zero.
  assign row_cur = rd_valid_r ? row_rdata : '0;
  assign {cur_alloc, cur_need} = row_cur;

  always_comb begin
    for (int e = 0; e < MAX_RES; e++) begin
      lane_on[e] = (RCNT_W'(e) < nr);
    end
  end

  assign row_bad = (CMP_W'(pidx_r) >= CMP_W'(np));

  always_comb begin
    limit_bad = 1'b0;
    refuse    = STS_OK;
    for (int e = 0; e < MAX_RES; e++) begin
      if (lane_on[e] && (lim_r[e] < amt_r[e])) limit_bad = 1'b1;
      // Lanes in ascending order; the need test wins over the available test.
      if (lane_on[e] && refuse == STS_OK) begin
        if (amt_r[e] > cur_need[e]) begin
          refuse = STS_EXCEEDS_NEED;
        end else if (amt_r[e] > avail_r[e]) begin
          refuse = STS_EXCEEDS_AVAIL;
        end
      end
    end
  end

  always_comb begin
    for (int e = 0; e < MAX_RES; e++) begin
      ld_alloc[e] = lane_on[e] ? amt_r[e] : '0;
      ld_need[e]  = lane_on[e] ? (lim_r[e] - amt_r[e]) : '0;
      ap_alloc[e] = lane_on[e] ? (cur_alloc[e] + amt_r[e]) : cur_alloc[e];
      ap_need[e]  = lane_on[e] ? (cur_need[e] - amt_r[e]) : cur_need[e];
    end
  end

  assign row_we    = cmd.load_row | cmd.apply_req | cmd.undo_req;
  assign row_waddr = IDX_W'(pidx_r);
  assign row_wdata = cmd.load_row  ? {ld_alloc, ld_need} :
                     cmd.apply_req ? {ap_alloc, ap_need} : backup_r;
  assign row_raddr = cmd.read_req_row ? IDX_W'(pidx_r) : scan_r[IDX_W-1:0];

  bsa_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_PROCS)
  ) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .raddr (row_raddr),
    .rdata (row_rdata)
  );

  // Search: rows are read one per cycle and tested in the cycle after. A hit
  // restarts the scan from row zero and drops the row already in flight.
  always_comb begin
    fits = 1'b1;
    for (int e = 0; e < MAX_RES; e++) begin
      if (lane_on[e] && (work_r[e] < WORK_W'(cur_need[e]))) fits = 1'b0;
    end
  end

  assign issue_vld   = (scan_r < np);
  assign hit         = cmd.search_run && cmp_vld_r && !fin_r[cmp_idx_r] && fits;
  assign pass_end    = (CNT_W'(cmp_idx_r) == (np - CNT_W'(1)));
  assign search_done = hit && ((taken_r + CNT_W'(1)) == np);
  assign search_fail = cmd.search_run && cmp_vld_r && !hit && pass_end;
  assign emit_last   = (emit_r == (np - CNT_W'(1)));

  bsa_ram #(
    .WIDTH (PIDX_W),
    .DEPTH (MAX_PROCS)
  ) u_order_ram (
    .clk   (clk),
    .we    (hit),
    .waddr (taken_r[IDX_W-1:0]),
    .wdata (PIDX_W'(cmp_idx_r)),
    .raddr (emit_r[IDX_W-1:0]),
    .rdata (ord_rdata)
  );

  always_comb begin
    avail_nxt = avail_r;
    work_nxt  = work_r;
    for (int e = 0; e < MAX_RES; e++) begin
      if (cmd.set_avail) begin
        avail_nxt[e] = lane_on[e] ? amt_r[e] : '0;
      end else if (cmd.apply_req && lane_on[e]) begin
        avail_nxt[e] = avail_r[e] - amt_r[e];
      end else if (cmd.undo_req && lane_on[e]) begin
        avail_nxt[e] = avail_r[e] + amt_r[e];
      end
      if (cmd.search_init) begin
        work_nxt[e] = lane_on[e] ? WORK_W'(avail_r[e]) : '0;
      end else if (hit && lane_on[e]) begin
        work_nxt[e] = work_r[e] + WORK_W'(cur_alloc[e]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avail_r        <= '0;
      work_r         <= '0;
      row_valid_r    <= '0;
      rd_valid_r     <= 1'b0;
      fin_r          <= '0;
      taken_r        <= '0;
      scan_r         <= '0;
      emit_r         <= '0;
      cmp_idx_r      <= '0;
      cmp_vld_r      <= 1'b0;
      res_vld_r      <= 1'b0;
      res_last_r     <= 1'b0;
      res_from_ord_r <= 1'b0;
      res_status_r   <= STS_OK;
    end else begin
      avail_r    <= avail_nxt;
      work_r     <= work_nxt;
      rd_valid_r <= row_valid_r[row_raddr];
      cmp_idx_r  <= scan_r[IDX_W-1:0];
      if (row_we) row_valid_r[row_waddr] <= 1'b1;

      if (cmd.search_init) begin
        fin_r     <= '0;
        taken_r   <= '0;
        scan_r    <= '0;
        emit_r    <= '0;
        cmp_vld_r <= 1'b0;
      end else if (cmd.search_run) begin
        cmp_vld_r <= issue_vld && !hit;
        if (hit) begin
          fin_r[cmp_idx_r] <= 1'b1;
          taken_r          <= taken_r + CNT_W'(1);
          scan_r           <= '0;
        end else if (issue_vld) begin
          scan_r <= scan_r + CNT_W'(1);
        end
      end else begin
        cmp_vld_r <= 1'b0;
        if (cmd.emit_step) emit_r <= emit_r + CNT_W'(1);
      end

      res_vld_r <= cmd.single_vld | cmd.emit_step;
      if (cmd.single_vld) begin
        res_status_r   <= cmd.single_status;
        res_last_r     <= 1'b1;
        res_from_ord_r <= 1'b0;
      end else if (cmd.emit_step) begin
        res_status_r   <= STS_OK;
        res_last_r     <= emit_last;
        res_from_ord_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_type_r <= req_type_t'(in_req_type);
      pidx_r     <= in_process_index;
      for (int e = 0; e < MAX_RES; e++) begin
        amt_r[e] <= AMOUNT_WIDTH'(in_amount[e]);
        lim_r[e] <= AMOUNT_WIDTH'(in_limit[e]);
      end
    end
    if (cmd.apply_req) backup_r <= row_cur;
  end

  always_comb begin
    sts.req_type      = req_type_r;
    sts.row_bad       = row_bad;
    sts.limit_bad     = limit_bad;
    sts.refuse_status = refuse;
    sts.search_done   = search_done;
    sts.search_fail   = search_fail;
    sts.emit_last     = emit_last;
  end

  assign out_strobe        = res_vld_r;
  assign out_status        = res_status_r;
  assign out_last          = res_last_r;
  assign out_order_process = res_from_ord_r ? ord_rdata : '0;

endmodule

`default_nettype wire

### rtl/core/bankers_safe_allocator.sv
// Top level of the banker's-algorithm safe allocator: configuration registers,
// controller and datapath. Depends on bsa_pkg, bsa_ctrl, bsa_datapath.
//
// Use: a transaction on the command channel is taken when start is high and
// busy is low. It loads a process row, sets the available vector, asks for a
// safety check or requests resources. Results leave on out_* for exactly one
// cycle each, marked by out_strobe; out_last marks the final one of a
// transaction. The receiver cannot stall, so the block never waits on it.
// Load row, set available and rows out of range are answered from the decode
// state, a refused request from the request check state, each through a register.
// A safety search tests one row per cycle through the registered read port of
// the row memory, except that each hit drops the row in flight and restarts the
// scan at row zero. When the search finds a safe order, the order is emitted,
// one result per process in use. Busy stays high until the last result is on
// the ports; one transaction is worked at a time. Reset (synchronous, rst_n low)
// marks every row of the row table as unwritten, clears the available vector and
// sets process_count to 8 and resource_count to 4. Configuration is at byte
// addresses 0 and 4 of the APB port; pready is always high.
`timescale 1ns / 1ps
`default_nettype none

module bankers_safe_allocator import bsa_pkg::*; #(
  parameter int MAX_PROCS = 8,
  parameter int MAX_RES = 4,
  parameter int AMOUNT_WIDTH = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_req_type,
  input  logic [PIDX_W-1:0]     in_process_index,
  input  logic [LANE_W-1:0]     in_amount_0,
  input  logic [LANE_W-1:0]     in_amount_1,
  input  logic [LANE_W-1:0]     in_amount_2,
  input  logic [LANE_W-1:0]     in_amount_3,
  input  logic [LANE_W-1:0]     in_limit_0,
  input  logic [LANE_W-1:0]     in_limit_1,
  input  logic [LANE_W-1:0]     in_limit_2,
  input  logic [LANE_W-1:0]     in_limit_3,
  output logic                  out_strobe,
  output logic [STATUS_W-1:0]   out_status,
  output logic [PIDX_W-1:0]     out_order_process,
  output logic                  out_last,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int CNT_W = $clog2(MAX_PROCS + 1);

  logic [PCNT_W-1:0] proc_count_r;
  logic [RCNT_W-1:0] res_count_r;
  logic [CNT_W-1:0]  np;
  logic [RCNT_W-1:0] nr;
  logic              cfg_write;
  lane_vec_t         amounts, limits;
  dp_cmd_t           cmd;
  dp_sts_t           sts;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      proc_count_r <= PROC_COUNT_RST;
      res_count_r  <= RES_COUNT_RST;
    end else if (cfg_write) begin
      if (paddr[2] == REG_PROC_COUNT) begin
        proc_count_r <= pwdata[PCNT_W-1:0];
      end else begin
        res_count_r <= pwdata[RCNT_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_RES_COUNT) ? CFG_DATA_W'(res_count_r)
                                              : CFG_DATA_W'(proc_count_r);

  // Counts outside the supported range are clamped into it.
  always_comb begin
    if (proc_count_r == '0) begin
      np = CNT_W'(1);
    end else if (int'(proc_count_r) > MAX_PROCS) begin
      np = CNT_W'(MAX_PROCS);
    end else begin
      np = CNT_W'(proc_count_r);
    end
    if (res_count_r == '0) begin
      nr = RCNT_W'(1);
    end else if (int'(res_count_r) > MAX_RES) begin
      nr = RCNT_W'(MAX_RES);
    end else begin
      nr = res_count_r;
    end
  end

  assign amounts = {in_amount_3, in_amount_2, in_amount_1, in_amount_0};
  assign limits  = {in_limit_3, in_limit_2, in_limit_1, in_limit_0};

  bsa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  bsa_datapath #(
    .MAX_PROCS    (MAX_PROCS),
    .MAX_RES      (MAX_RES),
    .AMOUNT_WIDTH (AMOUNT_WIDTH)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .np                (np),
    .nr                (nr),
    .in_req_type       (in_req_type),
    .in_process_index  (in_process_index),
    .in_amount         (amounts),
    .in_limit          (limits),
    .out_strobe        (out_strobe),
    .out_status        (out_status),
    .out_order_process (out_order_process),
    .out_last          (out_last)
  );

endmodule

`default_nettype wire

### rtl/core/bsa_checker.sv
// Port-level checker of the safe allocator and its bind to the top level.
// Depends on bsa_pkg and bankers_safe_allocator_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "bankers_safe_allocator_assert.svh"

module bsa_checker import bsa_pkg::*; (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                start,
  input wire logic                busy,
  input wire logic                out_strobe,
  input wire logic [STATUS_W-1:0] out_status,
  input wire logic [PIDX_W-1:0]   out_order_process,
  input wire logic                out_last
);

  // A taken transaction always makes the block busy in the next cycle.
  `BSA_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  // Results only appear after the block has been working.
  `BSA_ASSERT_SAME(a_result_after_work, clk, rst_n, out_strobe, $past(busy))
  // Refusals and unsafe outcomes are single results with no process number.
  `BSA_ASSERT_SAME(a_refusal_single, clk, rst_n, out_strobe && out_status != STS_OK, out_last && out_order_process == '0)
  // The final result of a transaction leaves the block free.
  `BSA_ASSERT_SAME(a_last_frees, clk, rst_n, out_strobe && out_last, !busy)
  // While a safe order is still being sent the block stays busy.
  `BSA_ASSERT_SAME(a_more_follow, clk, rst_n, out_strobe && !out_last, busy)

endmodule

bind bankers_safe_allocator bsa_checker u_bsa_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_strobe        (out_strobe),
  .out_status        (out_status),
  .out_order_process (out_order_process),
  .out_last          (out_last)
);

`default_nettype wire
